// ===== design/tmaf_pkg.sv =====
// ----------------------------------------------------------------------------
// tmaf_pkg
// Shared constants and types of the trimmed moving-average filter.
// ----------------------------------------------------------------------------
package tmaf_pkg;

    localparam int WINDOW    = 10;                  // window length, 3..64
    localparam int SMP_W     = 16;                  // sample / result width
    localparam int AW        = $clog2(WINDOW);      // window memory address
    localparam int CW        = $clog2(WINDOW + 1);  // counts up to WINDOW
    localparam int SUM_W     = SMP_W + $clog2(WINDOW);
    localparam int DIVISOR   = WINDOW - 2;

    // Rounded-up reciprocal of DIVISOR; floor(n * RCP_M / 2^RCP_SH) equals
    // floor(n / DIVISOR) for every n below 2^SUM_W
    localparam int RCP_SH    = SUM_W + $clog2(DIVISOR);
    localparam int RCP_W     = SUM_W + 1;
    localparam longint RCP   = ((longint'(1) << RCP_SH) + longint'(DIVISOR) - 1)
                               / longint'(DIVISOR);
    localparam logic [RCP_W-1:0] RCP_M = RCP_W'(RCP);

    typedef logic signed [SMP_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0] t_sum;

    // Request from the sequencer to the window memory
    typedef struct packed {
        logic            wr_en;
        t_sample         wr_data;
        logic            rd_en;
        logic [AW-1:0]   rd_addr;
    } t_win_req;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== design/tmaf_stream_if.sv =====
// ----------------------------------------------------------------------------
// tmaf_sample_if / tmaf_result_if
// Valid/ready channels for input samples and filtered results.
// ----------------------------------------------------------------------------
interface tmaf_sample_if
    import tmaf_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface tmaf_result_if
    import tmaf_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

// ===== design/tmaf_window.sv =====
// ----------------------------------------------------------------------------
// tmaf_window
// Circular sample memory of WINDOW entries with a registered read port.
// Entries not yet written since reset read as zero (tracked by a fill count).
// ----------------------------------------------------------------------------
module tmaf_window
    import tmaf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_win_req i_req,
    output t_sample  o_rd_data
);

    t_sample       r_mem [WINDOW];
    logic [AW-1:0] r_wr_ptr;
    logic [CW-1:0] r_fill;
    t_sample       r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_fill   <= '0;
        end else if (i_req.wr_en) begin
            r_wr_ptr <= (r_wr_ptr == AW'(WINDOW - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (r_fill != CW'(WINDOW)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[r_wr_ptr] <= i_req.wr_data;
        end
    end

    // writes fill entries in ascending order, so entry k is live once k < fill
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= (CW'(i_req.rd_addr) < r_fill) ? r_mem[i_req.rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/tmaf_divider.sv =====
// ----------------------------------------------------------------------------
// tmaf_divider
// Signed division by WINDOW-2, truncating toward zero. The magnitude is
// multiplied by a rounded-up reciprocal; the dividend is registered on
// start, and the quotient is registered while busy, as done is raised.
// ----------------------------------------------------------------------------
module tmaf_divider
    import tmaf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_sum      i_dividend,
    output t_div_stat o_stat,
    output t_sample   o_quotient
);

    logic                     r_busy;
    logic                     r_done;
    logic                     r_neg;
    logic [SUM_W-1:0]         r_mag;
    logic [SMP_W-1:0]         r_quo;
    logic [SUM_W-1:0]         mag;
    logic [SUM_W+RCP_W-1:0]   prod;

    assign mag  = i_dividend[SUM_W-1] ? (~i_dividend) + SUM_W'(1) : i_dividend;
    assign prod = r_mag * RCP_M;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_mag <= mag;
        end else if (r_busy) begin
            // magnitude of the quotient always fits the sample width
            r_quo <= prod[RCP_SH +: SMP_W];
        end
    end

    assign o_quotient  = r_neg ? (~r_quo) + SMP_W'(1) : r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== design/trimmed_moving_average_filter_unit.sv =====
// ----------------------------------------------------------------------------
// trimmed_moving_average_filter_unit
// Moving average over the last WINDOW samples with the largest and the
// smallest sample rejected.
//
// Usage:
//   i_sample_ch carries one signed 16-bit sample per transfer; o_result_ch
//   returns one filtered value per sample, in order. Each result is the sum
//   of the window (new sample included) less its maximum and minimum,
//   divided by WINDOW-2 and truncated toward zero.
//   One sample is processed at a time: the window memory is read one entry
//   per cycle to build the sum, maximum and minimum, then a reciprocal
//   multiplication in the divider gives the quotient. The next sample is
//   taken in the cycle after a result is loaded.
//   The result sits in an output register; a new sample is accepted while
//   it waits, but the following result holds in the divider until the
//   receiver takes the pending one.
//   Reset: the window reads as all zeros and the zeros count in the first
//   results until real samples replace them. No clearing pass is needed.
// ----------------------------------------------------------------------------
module trimmed_moving_average_filter_unit
    import tmaf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    tmaf_sample_if.sink         i_sample_ch,
    tmaf_result_if.source       o_result_ch
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_TRIM = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [CW-1:0] r_rd_cnt;
    logic          r_acc_vld;
    logic          r_acc_first;
    logic          r_acc_last;
    t_sum          r_sum;
    t_sample       r_max;
    t_sample       r_min;
    logic          r_out_vld;
    t_sample       r_out_data;

    t_win_req      win_req;
    t_sample       rd_data;
    t_div_stat     div_stat;
    t_sample       div_quo;
    logic          in_xfer;
    logic          issue;
    logic          div_start;
    logic          out_free;
    logic          out_load;
    t_sum          trimmed;

    assign in_xfer   = i_sample_ch.valid && i_sample_ch.ready;
    assign issue     = (r_state == ST_SCAN) && (r_rd_cnt != CW'(WINDOW));
    assign div_start = (r_state == ST_TRIM);
    assign out_free  = !r_out_vld || o_result_ch.ready;
    assign out_load  = (r_state == ST_DIV) && div_stat.done && out_free;
    assign trimmed   = r_sum - SUM_W'(r_max) - SUM_W'(r_min);

    assign win_req.wr_en   = in_xfer;
    assign win_req.wr_data = i_sample_ch.sample;
    assign win_req.rd_en   = issue;
    assign win_req.rd_addr = r_rd_cnt[AW-1:0];

    tmaf_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (win_req),
        .o_rd_data (rd_data)
    );

    tmaf_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (trimmed),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_xfer)          n_state = ST_SCAN;
            ST_SCAN: if (r_acc_last)       n_state = ST_TRIM;
            ST_TRIM:                       n_state = ST_DIV;
            ST_DIV:  if (out_load)         n_state = ST_IDLE;
            default:                       n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_cnt    <= '0;
            r_acc_vld   <= 1'b0;
            r_acc_first <= 1'b0;
            r_acc_last  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_acc_vld  <= issue;
            r_acc_last <= issue && (r_rd_cnt == CW'(WINDOW - 1));
            if (in_xfer) begin
                r_rd_cnt    <= '0;
                r_acc_first <= 1'b1;
            end else begin
                if (issue) begin
                    r_rd_cnt <= r_rd_cnt + 1'b1;
                end
                if (r_acc_vld) begin
                    r_acc_first <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_result_ch.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // read data arrives in the cycle after the read is issued
    always_ff @(posedge i_clk) begin
        if (r_acc_vld) begin
            if (r_acc_first) begin
                r_sum <= SUM_W'(rd_data);
                r_max <= rd_data;
                r_min <= rd_data;
            end else begin
                r_sum <= r_sum + SUM_W'(rd_data);
                if (rd_data > r_max) begin
                    r_max <= rd_data;
                end
                if (rd_data < r_min) begin
                    r_min <= rd_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= div_quo;
        end
    end

    assign i_sample_ch.ready    = (r_state == ST_IDLE);
    assign o_result_ch.valid    = r_out_vld;
    assign o_result_ch.filtered = r_out_data;

endmodule
